// File: src/pgg_pkg.sv
package pgg_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int LOG_BITS     = 24;
  localparam int X_FRAC       = 27;
  localparam int STEP_BITS    = 5;
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_NORM,
    ST_LOG,
    ST_SCALE,
    ST_DIV,
    ST_HMUL,
    ST_SQRT,
    ST_XFIN,
    ST_MUL,
    ST_FIN
  } state_t;

endpackage

// File: src/pgg_in_if.sv
interface pgg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean;
  logic        [30:0] sigma;
  logic        [31:0] uniform_a;
  logic        [31:0] uniform_b;

  modport source (output valid, mean, sigma, uniform_a, uniform_b, input ready);
  modport sink   (input valid, mean, sigma, uniform_a, uniform_b, output ready);
endinterface

// File: src/pgg_out_if.sv
interface pgg_out_if #(
  parameter int SAMPLE_WIDTH = pgg_pkg::SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           saturated;
  logic                           from_held;

  modport source (output valid, sample, saturated, from_held, input ready);
  modport sink   (input valid, sample, saturated, from_held, output ready);
endinterface

// File: src/polar_gaussian_generator.sv
// Channel  Direction  Payload
// item     in         mean, sigma, uniform_a, uniform_b
// result   out        sample, saturated, from_held
//
// A held value passes through ST_MUL and ST_FIN to its result beat, and a
// rejected pair returns to idle from ST_SQB. A fresh pair passes through the
// ST_SQA and ST_SQB squaring, one-place normalization, log squaring for
// LOG_BITS fraction bits, the scale state, then for each of its two values the
// divide, multiply, root and finish states, and the ST_MUL and ST_FIN states.
// One 32 by 32 multiplier is shared by every product. Reset is synchronous
// and clears the held value. A result beat waits in the output register while
// the sink stalls, and the next item then waits in its last cycle.
module polar_gaussian_generator #(
  parameter int SAMPLE_WIDTH = pgg_pkg::SAMPLE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  pgg_in_if.sink    item,
  pgg_out_if.source result
);

  localparam logic signed [64:0] SAT_HI = (65'sd1 <<< (SAMPLE_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] SAT_LO = -SAT_HI - 65'sd1;

  pgg_pkg::state_t state, state_next;

  logic signed [31:0] mean_r;
  logic        [30:0] sigma_r;
  logic        [31:0] ma, mb;
  logic               nega, negb;
  logic        [63:0] sq_a, sq_b, r_reg, nr;
  logic        [5:0]  s;
  logic        [31:0] y;
  logic        [23:0] frac;
  logic        [30:0] g;
  logic        [63:0] rem;
  logic        [31:0] q;
  logic        [63:0] v, res, bitr;
  logic        [pgg_pkg::STEP_BITS-1:0] cnt;
  logic               side;
  logic signed [31:0] xa, xe;
  logic               from_r;
  logic signed [63:0] pe;
  logic        [31:0] held_normal;
  logic               have_held;

  logic        [31:0] mul_a, mul_b;
  logic        [63:0] mul_p;
  logic        [64:0] r_sum, div_t;
  logic        [30:0] len;
  logic        [63:0] root_t;
  logic        [30:0] m;
  logic signed [31:0] x_new;
  logic        [31:0] xmag;
  logic signed [64:0] sum;
  logic               out_free, accept;

  assign accept   = item.valid && item.ready;
  assign out_free = !result.valid || result.ready;
  assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
  assign r_sum    = {1'b0, sq_a} + {1'b0, mul_p};
  assign len      = {({1'b0, s} + 7'd1), 24'd0} - {7'd0, frac};
  assign div_t    = {rem, 1'b0};
  assign root_t   = res + bitr;
  assign m        = res[31:1];
  assign x_new    = (side ? negb : nega) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  assign xmag     = xe[31] ? 32'(-xe) : 32'(xe);
  assign sum      = 65'(pe >>> pgg_pkg::X_FRAC) + 65'(mean_r);

  always_comb begin
    state_next = state;
    unique case (state)
      pgg_pkg::ST_IDLE:  if (accept) state_next = have_held ? pgg_pkg::ST_MUL : pgg_pkg::ST_SQA;
      pgg_pkg::ST_SQA:   state_next = pgg_pkg::ST_SQB;
      pgg_pkg::ST_SQB:   state_next = r_sum[64] ? pgg_pkg::ST_IDLE : pgg_pkg::ST_NORM;
      pgg_pkg::ST_NORM:  if (nr[63]) state_next = pgg_pkg::ST_LOG;
      pgg_pkg::ST_LOG:   if (cnt == pgg_pkg::STEP_BITS'(pgg_pkg::LOG_BITS - 1))
                           state_next = pgg_pkg::ST_SCALE;
      pgg_pkg::ST_SCALE: state_next = pgg_pkg::ST_DIV;
      pgg_pkg::ST_DIV:   if (&cnt) state_next = pgg_pkg::ST_HMUL;
      pgg_pkg::ST_HMUL:  state_next = pgg_pkg::ST_SQRT;
      pgg_pkg::ST_SQRT:  if (&cnt) state_next = pgg_pkg::ST_XFIN;
      pgg_pkg::ST_XFIN:  state_next = side ? pgg_pkg::ST_MUL : pgg_pkg::ST_DIV;
      pgg_pkg::ST_MUL:   state_next = pgg_pkg::ST_FIN;
      pgg_pkg::ST_FIN:   if (out_free) state_next = pgg_pkg::ST_IDLE;
      default:           state_next = pgg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = (state == pgg_pkg::ST_IDLE);
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state)
      pgg_pkg::ST_SQA:   begin mul_a = ma; mul_b = ma; end
      pgg_pkg::ST_SQB:   begin mul_a = mb; mul_b = mb; end
      pgg_pkg::ST_LOG:   begin mul_a = y;  mul_b = y;  end
      pgg_pkg::ST_SCALE: begin mul_a = {1'b0, len}; mul_b = {1'b0, pgg_pkg::TWO_LN2_Q30}; end
      pgg_pkg::ST_HMUL:  begin mul_a = {1'b0, g}; mul_b = q; end
      pgg_pkg::ST_MUL:   begin mul_a = {1'b0, sigma_r}; mul_b = xmag; end
      default:           begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pgg_pkg::ST_IDLE;
      have_held    <= 1'b0;
      held_normal  <= 32'd0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result.valid && result.ready && state != pgg_pkg::ST_FIN) result.valid <= 1'b0;
      unique case (state)
        pgg_pkg::ST_IDLE: if (accept) begin
          mean_r  <= item.mean;
          sigma_r <= item.sigma;
          ma   <= {item.uniform_a[31] ? item.uniform_a[30:0] : ~item.uniform_a[30:0], 1'b1};
          mb   <= {item.uniform_b[31] ? item.uniform_b[30:0] : ~item.uniform_b[30:0], 1'b1};
          nega <= !item.uniform_a[31];
          negb <= !item.uniform_b[31];
          side <= 1'b0;
          if (have_held) begin
            have_held <= 1'b0;
            xe        <= held_normal;
            from_r    <= 1'b1;
          end
        end
        pgg_pkg::ST_SQA: sq_a <= mul_p;
        pgg_pkg::ST_SQB: begin
          sq_b  <= mul_p;
          r_reg <= r_sum[63:0];
          nr    <= r_sum[63:0];
          s     <= 6'd0;
        end
        pgg_pkg::ST_NORM: begin
          if (nr[63]) begin
            y    <= nr[63:32];
            frac <= 24'd0;
            cnt  <= '0;
          end else begin
            nr <= {nr[62:0], 1'b0};
            s  <= s + 6'd1;
          end
        end
        pgg_pkg::ST_LOG: begin
          frac <= {frac[22:0], mul_p[63]};
          y    <= mul_p[63] ? mul_p[63:32] : mul_p[62:31];
          cnt  <= cnt + 1'b1;
        end
        pgg_pkg::ST_SCALE: begin
          g   <= mul_p[60:30];
          rem <= sq_a;
          q   <= 32'd0;
          cnt <= '0;
        end
        pgg_pkg::ST_DIV: begin
          if (div_t >= {1'b0, r_reg}) begin
            rem <= 64'(div_t - {1'b0, r_reg});
            q   <= {q[30:0], 1'b1};
          end else begin
            rem <= div_t[63:0];
            q   <= {q[30:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        pgg_pkg::ST_HMUL: begin
          v    <= mul_p;
          res  <= 64'd0;
          bitr <= 64'd1 << 62;
          cnt  <= '0;
        end
        pgg_pkg::ST_SQRT: begin
          if (v >= root_t) begin
            v   <= v - root_t;
            res <= (res >> 1) + bitr;
          end else begin
            res <= res >> 1;
          end
          bitr <= bitr >> 2;
          cnt  <= cnt + 1'b1;
        end
        pgg_pkg::ST_XFIN: begin
          if (side) begin
            held_normal <= x_new;
            have_held   <= 1'b1;
            xe          <= xa;
            from_r      <= 1'b0;
          end else begin
            xa   <= x_new;
            side <= 1'b1;
            rem  <= sq_b;
            q    <= 32'd0;
            cnt  <= '0;
          end
        end
        pgg_pkg::ST_MUL: pe <= xe[31] ? -$signed(mul_p) : $signed(mul_p);
        pgg_pkg::ST_FIN: if (out_free) begin
          result.valid     <= 1'b1;
          result.from_held <= from_r;
          if (sum > SAT_HI) begin
            result.sample    <= SAT_HI[SAMPLE_WIDTH-1:0];
            result.saturated <= 1'b1;
          end else if (sum < SAT_LO) begin
            result.sample    <= SAT_LO[SAMPLE_WIDTH-1:0];
            result.saturated <= 1'b1;
          end else begin
            result.sample    <= sum[SAMPLE_WIDTH-1:0];
            result.saturated <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == pgg_pkg::ST_DIV |-> rem < r_reg)
    else $error("divider remainder reached the radius");
  a_hold_set: assert property (@(posedge clk) disable iff (rst)
    (state == pgg_pkg::ST_XFIN && side) |=> have_held && state == pgg_pkg::ST_MUL)
    else $error("second value was not held");
  a_held_use: assert property (@(posedge clk) disable iff (rst)
    (accept && have_held) |=> !have_held && from_r)
    else $error("held value was not consumed");
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    (state == pgg_pkg::ST_FIN && out_free) |=> result.valid && state == pgg_pkg::ST_IDLE)
    else $error("result beat was not issued");
`endif

endmodule

// File: test/tb_polar_gaussian_generator.sv
module tb_polar_gaussian_generator;

  typedef struct {
    logic signed [31:0] mean;
    logic        [30:0] sigma;
    logic        [31:0] ua;
    logic        [31:0] ub;
    bit                 typed;
    logic signed [31:0] t_sample;
    bit                 t_sat;
    bit                 t_held;
  } stim_row_t;

  typedef struct {
    logic signed [pgg_pkg::SAMPLE_WIDTH-1:0] sample;
    bit                                      saturated;
    bit                                      from_held;
  } sample_beat_t;

  logic clk;
  logic rst;

  pgg_in_if  item_ch ();
  pgg_out_if result_ch ();

  polar_gaussian_generator dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  sample_beat_t pending_samples[$];
  logic [31:0]  held_x;
  bit           held_ok;
  int           err_count;
  int           n_items;
  int           n_rejected;
  int           n_from_held;
  int           n_clipped;
  bit           hold_off_req;
  stim_row_t    directed[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] uniform_to_mag(input logic [31:0] k, output bit neg);
    logic [63:0] kk;
    kk = {32'd0, k};
    if (k[31]) begin
      neg = 1'b0;
      return 2 * kk + 1 - 64'h1_0000_0000;
    end
    neg = 1'b1;
    return 64'hFFFF_FFFF - 2 * kk;
  endfunction

  function automatic logic [63:0] minus_two_ln(input logic [63:0] r_in);
    logic [63:0] r, y, sq, frac, len, s;
    r = r_in;
    s = 0;
    frac = 0;
    while (!r[63]) begin
      r = r << 1;
      s = s + 1;
    end
    y = r >> 32;
    for (int i = 0; i < pgg_pkg::LOG_BITS; i++) begin
      sq = y * y;
      frac = frac << 1;
      if (sq[63]) begin
        frac = frac | 1;
        y = sq >> 32;
      end else begin
        y = sq >> 31;
      end
    end
    len = ((s + 1) << pgg_pkg::LOG_BITS) - frac;
    return (len * {33'd0, pgg_pkg::TWO_LN2_Q30}) >> 30;
  endfunction

  function automatic logic [63:0] ratio_q32(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q = 0;
    rem = num;
    for (int i = 0; i < 32; i++) begin
      q = q << 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q = q | 1;
      end else begin
        rem = rem << 1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v_in);
    logic [63:0] v, res, b;
    v = v_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] normal_value(input logic [63:0] mag, input bit neg,
                                               input logic [63:0] g, input logic [63:0] r);
    logic [63:0] p, m;
    p = ratio_q32(mag * mag, r);
    m = root64(g * p) >> 1;
    return neg ? (32'd0 - m[31:0]) : m[31:0];
  endfunction

  function automatic sample_beat_t scale_and_clip(input logic signed [31:0] x,
                                                  input logic signed [31:0] mean,
                                                  input logic [30:0] sigma, input bit held);
    sample_beat_t o;
    logic signed [63:0] prod, sum, hi, lo;
    prod = $signed({33'd0, sigma}) * $signed({{32{x[31]}}, x});
    sum = (prod >>> pgg_pkg::X_FRAC) + $signed({{32{mean[31]}}, mean});
    hi = (64'sd1 <<< (pgg_pkg::SAMPLE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    o.saturated = 1'b0;
    if (sum > hi) begin
      sum = hi;
      o.saturated = 1'b1;
    end else if (sum < lo) begin
      sum = lo;
      o.saturated = 1'b1;
    end
    o.sample = sum[pgg_pkg::SAMPLE_WIDTH-1:0];
    o.from_held = held;
    return o;
  endfunction

  function automatic bit gaussian_step(input stim_row_t s, output sample_beat_t o);
    logic [63:0] ma, mb, sa, sb, g;
    logic [64:0] r;
    bit na, nb;
    logic [31:0] x1;
    if (held_ok) begin
      held_ok = 1'b0;
      o = scale_and_clip(held_x, s.mean, s.sigma, 1'b1);
      return 1'b1;
    end
    ma = uniform_to_mag(s.ua, na);
    mb = uniform_to_mag(s.ub, nb);
    sa = ma * ma;
    sb = mb * mb;
    r = {1'b0, sa} + {1'b0, sb};
    if (r[64] || r == 0) return 1'b0;
    g = minus_two_ln(r[63:0]);
    x1 = normal_value(ma, na, g, r[63:0]);
    held_x = normal_value(mb, nb, g, r[63:0]);
    held_ok = 1'b1;
    o = scale_and_clip(x1, s.mean, s.sigma, 1'b0);
    return 1'b1;
  endfunction

  task automatic offer(input stim_row_t s);
    sample_beat_t e;
    item_ch.valid     <= 1'b1;
    item_ch.mean      <= s.mean;
    item_ch.sigma     <= s.sigma;
    item_ch.uniform_a <= s.ua;
    item_ch.uniform_b <= s.ub;
    do @(posedge clk); while (!item_ch.ready);
    n_items++;
    if (gaussian_step(s, e)) begin
      if (s.typed) begin
        e.sample = s.t_sample;
        e.saturated = s.t_sat;
        e.from_held = s.t_held;
      end
      pending_samples.push_back(e);
    end else begin
      n_rejected++;
    end
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      item_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_uniform();
    case ($urandom_range(9))
      0: return 32'h8000_0000 + $urandom_range(255);
      1: return 32'h7FFF_FFFF - $urandom_range(255);
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      3: return 32'h8000_0000 ^ ($urandom() >> $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  function automatic stim_row_t pick_row();
    stim_row_t s;
    s.typed = 1'b0;
    s.t_sample = 0;
    s.t_sat = 0;
    s.t_held = 0;
    case ($urandom_range(7))
      0: s.mean = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2: s.mean = $urandom();
      default: s.mean = $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
    endcase
    case ($urandom_range(7))
      0: s.sigma = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
      1: s.sigma = 31'($urandom());
      default: s.sigma = 31'($urandom_range(31'h0400_0000));
    endcase
    s.ua = pick_uniform();
    s.ub = pick_uniform();
    return s;
  endfunction

  function automatic stim_row_t row(input logic [31:0] mean, input logic [30:0] sigma,
                                    input logic [31:0] ua, input logic [31:0] ub,
                                    input bit typed, input logic [31:0] ts,
                                    input bit tsat, input bit theld);
    stim_row_t s;
    s.mean = mean; s.sigma = sigma; s.ua = ua; s.ub = ub;
    s.typed = typed; s.t_sample = ts; s.t_sat = tsat; s.t_held = theld;
    return s;
  endfunction

  // The sink stalls in changing modes; a hold-off request keeps it low for a long stretch.
  initial begin
    int mode, left, hold_left;
    mode = 0;
    left = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && hold_left == 0) begin
        hold_left = 2000;
        hold_off_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(400, 50);
      end
      left--;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom_range(1));
          2: result_ch.ready <= ($urandom_range(3) == 0);
          default: result_ch.ready <= ($urandom_range(7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    sample_beat_t e;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result beat: sample %h", result_ch.sample);
        err_count++;
      end else begin
        e = pending_samples.pop_front();
        if (result_ch.sample !== e.sample) begin
          $error("sample: expected %h, actual %h", e.sample, result_ch.sample);
          err_count++;
        end
        if (result_ch.saturated !== e.saturated) begin
          $error("saturated: expected %0b, actual %0b", e.saturated, result_ch.saturated);
          err_count++;
        end
        if (result_ch.from_held !== e.from_held) begin
          $error("from_held: expected %0b, actual %0b", e.from_held, result_ch.from_held);
          err_count++;
        end
        if (e.from_held) n_from_held++;
        if (e.saturated) n_clipped++;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int burst;
    bit hold_asked, drained;
    err_count = 0;
    n_items = 0;
    n_rejected = 0;
    n_from_held = 0;
    n_clipped = 0;
    held_ok = 1'b0;
    held_x = 0;
    hold_off_req = 1'b0;
    hold_asked = 1'b0;
    drained = 1'b0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.mean = 0;
    item_ch.sigma = 0;
    item_ch.uniform_a = 0;
    item_ch.uniform_b = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With sigma zero the sample is just the mean; a tiny radius with full sigma clips.
    directed.push_back(row(32'h1234_5678, 31'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                           1, 32'h1234_5678, 0, 0));
    directed.push_back(row(32'h8765_4321, 31'd0, 32'h0000_0000, 32'h0000_0000,
                           1, 32'h8765_4321, 0, 1));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'h0000_0000, 32'h0000_0000,
                           0, 0, 0, 0));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           0, 0, 0, 0));
    directed.push_back(row(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                           1, 32'h7FFF_FFFF, 1, 0));
    directed.push_back(row(32'h8000_0000, 31'h7FFF_FFFF, 32'h1111_1111, 32'h2222_2222,
                           1, 32'h8000_0000, 1, 1));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'h0, 32'h0, 0, 0, 0, 0));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'h0000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0));
    directed.push_back(row(32'hFF00_0000, 31'h7FFF_FFFF, 32'h0, 32'h0, 0, 0, 0, 0));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
    directed.push_back(row(32'h0100_0000, 31'h0080_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                           0, 0, 0, 0));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'hC000_0000, 32'h4000_0000, 0, 0, 0, 0));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'h0, 32'h0, 0, 0, 0, 0));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'hB504_F333, 32'hB504_F333, 0, 0, 0, 0));
    directed.push_back(row(32'h0, 31'h0100_0000, 32'h0, 32'h0, 0, 0, 0, 0));
    foreach (directed[i]) offer(directed[i]);
    idle_cycles(1);

    for (int n = 0; n < 1050; ) begin
      if (n >= 300 && !hold_asked) begin
        hold_off_req = 1'b1;
        hold_asked = 1'b1;
      end
      if (n >= 600 && !drained) begin
        item_ch.valid <= 1'b0;
        drained = 1'b1;
        while (pending_samples.size() != 0) @(posedge clk);
      end
      burst = $urandom_range(40, 1);
      for (int j = 0; j < burst && n < 1050; j++, n++) offer(pick_row());
      idle_cycles($urandom_range(3) == 0 ? $urandom_range(300, 1) : $urandom_range(3));
    end
    item_ch.valid <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Sent %0d items: %0d rejected pairs, %0d samples from held values, %0d clipped.",
             n_items, n_rejected, n_from_held, n_clipped);
    $display("Covered field extremes, rejection, saturation both ways and long sink stalls.");
    if (err_count == 0 && pending_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/pgg_pkg.sv
src/pgg_in_if.sv
src/pgg_out_if.sv
src/polar_gaussian_generator.sv
test/tb_polar_gaussian_generator.sv
